FILE: src/run_length_bitmap_decoder_core_macros.svh
// Assertion macros for the run-length bitmap decoder.
`ifndef RUN_LENGTH_BITMAP_DECODER_CORE_MACROS_SVH
`define RUN_LENGTH_BITMAP_DECODER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RLBD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rlbd assertion failed");

// Next-cycle implication, checked out of reset.
`define RLBD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rlbd assertion failed");

`endif

FILE: src/rlbd_pkg.sv
// Package: types and constants of the run-length bitmap decoder.
package rlbd_pkg;

	localparam int unsigned TOTAL_BYTES = 32768;
	localparam int unsigned END_BITS    = TOTAL_BYTES * 8;
	localparam int unsigned POS_W       = $clog2(END_BITS) + 1;
	localparam int unsigned IDX_W       = 15;

	localparam logic CMD_PLACE = 1'b0;
	localparam logic CMD_RUN   = 1'b1;

	localparam logic [1:0] NEED_PLACE = 2'd0;
	localparam logic [1:0] NEED_RUN   = 2'd1;
	localparam logic [1:0] NEED_DONE  = 2'd2;

	typedef struct packed {
		logic       cmd;
		logic [7:0] skip;
		logic [7:0] count;
		logic [7:0] run_byte;
	} in_item_t;

	typedef struct packed {
		logic             byte_valid;
		logic [7:0]       data_byte;
		logic [IDX_W-1:0] byte_index;
		logic             last;
		logic [1:0]       next_needed;
	} out_item_t;

endpackage

FILE: src/rlbd_in_if.sv
// Input channel interface of the run-length bitmap decoder.
interface rlbd_in_if;
	import rlbd_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: src/rlbd_out_if.sv
// Result channel interface of the run-length bitmap decoder.
interface rlbd_out_if;
	import rlbd_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: src/run_length_bitmap_decoder_core.sv
// Run-length bitmap decoder core: bit-serial placement of skips and runs into bitmap bytes.
//
// Items are taken one at a time. An item is accepted, then each skipped or placed
// bit is shifted into the bit-serial shift register that builds each byte, then the
// skip phase and the placing phase are left in turn and the closing result is issued;
// a run byte has no skip phase, and an ignored item goes straight to its closing
// result. Completed bytes are held one deep so the final one can carry last and
// next_needed; bit placement pauses when a byte completes while one is already held
// and the result register is full and cannot drain, and the closing result waits
// until the result register is free. Ready is high only between items.
module run_length_bitmap_decoder_core (
	input  logic clk,
	input  logic arst_n,
	rlbd_in_if.sink    items,
	rlbd_out_if.source results
);
	import rlbd_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SKIP   = 2'd1;
	localparam logic [1:0] ST_PLACE  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	localparam logic [POS_W-1:0] END_POS = POS_W'(END_BITS);

	logic [1:0]       state_q;
	logic [POS_W-1:0] pos_q;
	logic             value_q;
	logic [7:0]       run_rem_q;
	logic [7:0]       place_rem_q;
	logic [7:0]       skip_rem_q;
	logic [7:0]       partial_q;
	logic             header_q;
	logic             pend_valid_q;
	logic [7:0]       pend_byte_q;
	logic [IDX_W-1:0] pend_idx_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic [1:0] need;
	logic       accept;
	logic       out_free;
	logic       at_end;
	logic       step_active;
	logic       step_bit;
	logic       byte_done;
	logic       step_go;
	logic       finish_go;
	logic       push_out;
	logic       run_ok;
	logic       place_ok;
	logic [7:0] shifted;

	always_comb begin
		if (!header_q) begin
			need = NEED_RUN;
		end else if (place_rem_q != 8'd0) begin
			need = (run_rem_q == 8'd0) ? NEED_RUN : NEED_PLACE;
		end else if (pos_q >= END_POS) begin
			need = NEED_DONE;
		end else begin
			need = NEED_PLACE;
		end
	end

	assign items.ready = (state_q == ST_IDLE);
	assign accept      = items.valid && items.ready;
	assign out_free    = !out_valid_q || results.ready;
	assign at_end      = (pos_q >= END_POS);
	assign run_ok      = (need != NEED_DONE) && (items.data.cmd == CMD_RUN) && (need == NEED_RUN);
	assign place_ok    = (need != NEED_DONE) && (items.data.cmd == CMD_PLACE)
		&& (need == NEED_PLACE);

	always_comb begin
		case (state_q)
			ST_SKIP: begin
				step_active = (skip_rem_q != 8'd0);
				step_bit    = 1'b0;
			end
			ST_PLACE: begin
				step_active = (place_rem_q != 8'd0) && (run_rem_q != 8'd0);
				step_bit    = value_q;
			end
			default: begin
				step_active = 1'b0;
				step_bit    = 1'b0;
			end
		endcase
	end

	assign shifted   = {step_bit, partial_q[7:1]};
	assign byte_done = step_active && !at_end && (pos_q[2:0] == 3'b111);
	assign step_go   = step_active && (!byte_done || !pend_valid_q || out_free);
	assign finish_go = (state_q == ST_FINISH) && out_free;
	assign push_out  = (step_go && byte_done && pend_valid_q) || finish_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pos_q        <= '0;
			value_q      <= 1'b1;
			run_rem_q    <= 8'd0;
			place_rem_q  <= 8'd0;
			skip_rem_q   <= 8'd0;
			partial_q    <= 8'd0;
			header_q     <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (push_out) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end

			if (step_go && !at_end) begin
				partial_q <= byte_done ? 8'd0 : shifted;
				pos_q     <= pos_q + 1'b1;
			end
			if (step_go && byte_done) begin
				pend_valid_q <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (run_ok) begin
							header_q  <= 1'b1;
							run_rem_q <= header_q ? items.data.run_byte
								: {1'b0, items.data.run_byte[7:1]};
							if (header_q) begin
								value_q <= !value_q;
							end
							state_q <= ST_PLACE;
						end else if (place_ok) begin
							skip_rem_q  <= items.data.skip;
							place_rem_q <= items.data.count;
							state_q     <= ST_SKIP;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_SKIP: begin
					if (!step_active) begin
						state_q <= ST_PLACE;
					end else if (step_go) begin
						skip_rem_q <= skip_rem_q - 8'd1;
					end
				end
				ST_PLACE: begin
					if (!step_active) begin
						state_q <= ST_FINISH;
					end else if (step_go) begin
						run_rem_q   <= run_rem_q - 8'd1;
						place_rem_q <= place_rem_q - 8'd1;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step_go && byte_done) begin
			pend_byte_q <= shifted;
			pend_idx_q  <= IDX_W'(pos_q >> 3);
		end
		if (push_out) begin
			if (finish_go) begin
				out_q.byte_valid  <= pend_valid_q;
				out_q.data_byte   <= pend_valid_q ? pend_byte_q : 8'd0;
				out_q.byte_index  <= pend_valid_q ? pend_idx_q : '0;
				out_q.last        <= 1'b1;
				out_q.next_needed <= need;
			end else begin
				out_q.byte_valid  <= 1'b1;
				out_q.data_byte   <= pend_byte_q;
				out_q.byte_index  <= pend_idx_q;
				out_q.last        <= 1'b0;
				out_q.next_needed <= NEED_PLACE;
			end
		end
	end

	assign results.valid = out_valid_q;
	assign results.data  = out_q;

`include "run_length_bitmap_decoder_core_macros.svh"

	`RLBD_ASSERT_NOW(a_pend_not_idle, pend_valid_q, state_q != ST_IDLE)
	`RLBD_ASSERT_NOW(a_pos_in_range, 1'b1, pos_q <= END_POS)
	`RLBD_ASSERT_NEXT(a_accept_busy, accept, state_q != ST_IDLE)
	`RLBD_ASSERT_NOW(a_idle_settled, state_q == ST_IDLE, place_rem_q == 8'd0 || run_rem_q == 8'd0)

endmodule

FILE: sim/rlbd_bitmap_scoreboard_pkg.sv
// Bitmap prediction and result scoreboard for the run-length bitmap decoder testbench.
package rlbd_bitmap_scoreboard_pkg;
	import rlbd_pkg::*;

	class bitmap_scoreboard;
		int unsigned bit_pos;
		logic        run_value;
		logic [7:0]  run_left;
		logic [7:0]  place_left;
		logic [7:0]  byte_acc;
		logic        header_taken;
		out_item_t   pending_results[$];
		int unsigned errors;

		function new();
			bit_pos      = 0;
			run_value    = 1'b1;
			run_left     = '0;
			place_left   = '0;
			byte_acc     = '0;
			header_taken = 1'b0;
			errors       = 0;
		endfunction

		function logic [1:0] next_kind();
			if (!header_taken)
				return NEED_RUN;
			if (place_left != 0)
				return (run_left == 0) ? NEED_RUN : NEED_PLACE;
			if (bit_pos >= END_BITS)
				return NEED_DONE;
			return NEED_PLACE;
		endfunction

		function void push_bit(logic b);
			out_item_t r;
			if (bit_pos >= END_BITS)
				return;
			byte_acc[bit_pos[2:0]] = b;
			bit_pos++;
			if (bit_pos % 8 == 0) begin
				r.byte_valid  = 1'b1;
				r.data_byte   = byte_acc;
				r.byte_index  = IDX_W'(bit_pos / 8 - 1);
				r.last        = 1'b0;
				r.next_needed = '0;
				pending_results.push_back(r);
				byte_acc = '0;
			end
		endfunction

		function void place_runs();
			while (place_left != 0 && run_left != 0) begin
				push_bit(run_value);
				run_left--;
				place_left--;
			end
		endfunction

		// Works out every result of one accepted input transaction.
		function void take_item(in_item_t it);
			int unsigned queued;
			logic [1:0]  kind;
			out_item_t   r;
			queued = pending_results.size();
			kind   = next_kind();
			if (kind == NEED_RUN && it.cmd == CMD_RUN) begin
				if (!header_taken) begin
					header_taken = 1'b1;
					run_left     = it.run_byte >> 1;
				end else begin
					run_value = ~run_value;
					run_left  = it.run_byte;
				end
				place_runs();
			end else if (kind == NEED_PLACE && it.cmd == CMD_PLACE) begin
				repeat (it.skip)
					push_bit(1'b0);
				place_left = it.count;
				place_runs();
			end
			if (pending_results.size() == queued)
				r = '0;
			else
				r = pending_results.pop_back();
			r.last        = 1'b1;
			r.next_needed = next_kind();
			pending_results.push_back(r);
		endfunction

		function void note_mismatch(string field, logic [31:0] want, logic [31:0] got,
			longint unsigned stamp);
			errors++;
			$display("%0d ns: %s mismatch, expected %0h, actual %0h", stamp, field, want, got);
		endfunction

		function void check_result(out_item_t got, longint unsigned stamp);
			out_item_t want;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0d ns: unexpected result, expected none, actual %h", stamp, got);
				return;
			end
			want = pending_results.pop_front();
			if (got.byte_valid !== want.byte_valid)
				note_mismatch("byte_valid", 32'(want.byte_valid), 32'(got.byte_valid), stamp);
			if (got.data_byte !== want.data_byte)
				note_mismatch("data_byte", 32'(want.data_byte), 32'(got.data_byte), stamp);
			if (got.byte_index !== want.byte_index)
				note_mismatch("byte_index", 32'(want.byte_index), 32'(got.byte_index), stamp);
			if (got.last !== want.last)
				note_mismatch("last", 32'(want.last), 32'(got.last), stamp);
			if (got.next_needed !== want.next_needed)
				note_mismatch("next_needed", 32'(want.next_needed), 32'(got.next_needed),
					stamp);
		endfunction
	endclass

endpackage

FILE: sim/tb_run_length_bitmap_decoder_core.sv
// Testbench of the run-length bitmap decoder core: directed and random transactions.
module tb_run_length_bitmap_decoder_core;
	timeunit 1ns;
	timeprecision 1ps;

	import rlbd_pkg::*;
	import rlbd_bitmap_scoreboard_pkg::*;

	localparam int unsigned RANDOM_ITEMS  = 300;
	localparam int unsigned STALL_LIMIT   = 4000;
	localparam int unsigned SETTLE_CYCLES = 24;

	logic        clk = 1'b0;
	logic        arst_n;
	bit          send_idle;
	bit          take_idle;
	int unsigned quiet_cycles = 0;

	rlbd_in_if  items_ch();
	rlbd_out_if results_ch();

	bitmap_scoreboard board = new();

	run_length_bitmap_decoder_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_ch),
		.results(results_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic in_item_t mk_place(logic [7:0] skip, logic [7:0] count);
		in_item_t it;
		it.cmd      = CMD_PLACE;
		it.skip     = skip;
		it.count    = count;
		it.run_byte = 8'($urandom_range(0, 255));
		return it;
	endfunction

	function automatic in_item_t mk_run(logic [7:0] run_byte);
		in_item_t it;
		it.cmd      = CMD_RUN;
		it.skip     = 8'($urandom_range(0, 255));
		it.count    = 8'($urandom_range(0, 255));
		it.run_byte = run_byte;
		return it;
	endfunction

	function automatic in_item_t rand_place();
		logic [7:0] skip;
		logic [7:0] count;
		skip  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 24));
		count = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 40));
		return mk_place(skip, count);
	endfunction

	function automatic in_item_t rand_run();
		case ($urandom_range(0, 7))
			0: return mk_run(8'd0);
			1, 2, 3: return mk_run(8'($urandom_range(1, 16)));
			default: return mk_run(8'($urandom_range(0, 255)));
		endcase
	endfunction

	task automatic send_item(in_item_t it);
		int unsigned gap;
		gap = send_idle ? $urandom_range(0, 9) : 0;
		if (gap != 0) begin
			items_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items_ch.valid <= 1'b1;
		items_ch.data  <= it;
		do @(posedge clk); while (!items_ch.ready);
		board.take_item(it);
	endtask

	task automatic drain_results();
		items_ch.valid <= 1'b0;
		do @(posedge clk); while (board.pending_results.size() != 0);
	endtask

	// Result side back-pressure
	initial begin
		int unsigned gap;
		results_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = take_idle ? $urandom_range(0, 9) : 0;
			if (gap != 0) begin
				results_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			results_ch.ready <= 1'b1;
			do @(posedge clk); while (!results_ch.valid);
		end
	end

	always @(posedge clk)
		if (arst_n && results_ch.valid && results_ch.ready)
			board.check_result(results_ch.data, $time);

	always @(posedge clk)
		if (arst_n) begin
			if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready))
				quiet_cycles <= 0;
			else if (quiet_cycles == STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end

	initial begin
		int unsigned useful;
		int unsigned n;
		logic [1:0]  kind;
		in_item_t    it;
		arst_n         = 1'b0;
		items_ch.valid <= 1'b0;
		items_ch.data  <= '0;
		send_idle      = 1'b1;
		take_idle      = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// header pending, header, wrong kinds, zero toggles, extremes
		send_item(mk_place(8'd5, 8'd5));
		send_item(mk_run(8'h01));
		send_item(mk_run(8'hAA));
		send_item(mk_place(8'd0, 8'd0));
		send_item(mk_place(8'd3, 8'd10));
		send_item(mk_place(8'd0, 8'd0));
		send_item(mk_run(8'd0));
		send_item(mk_run(8'd4));
		send_item(mk_run(8'hFF));
		send_item(mk_place(8'hFF, 8'hFF));
		send_item(mk_run(8'hFF));
		send_item(mk_place(8'd0, 8'hFF));
		send_item(mk_run(8'd0));
		send_item(mk_run(8'd0));
		send_item(mk_run(8'h80));
		send_item(mk_place(8'd1, 8'd1));
		send_item(mk_place(8'h80, 8'h7F));
		send_item(mk_run(8'h7F));
		send_item(mk_place(8'h7F, 8'h80));
		send_item(mk_run(8'h55));
		drain_results();

		useful = 0;
		n      = 0;
		while (useful < RANDOM_ITEMS) begin
			if (n % 50 == 0) begin
				send_idle = ($urandom_range(0, 3) != 0);
				take_idle = ($urandom_range(0, 3) != 0);
			end
			if ($urandom_range(0, 39) == 0)
				drain_results();
			kind = board.next_kind();
			if ($urandom_range(0, 99) < 85)
				it = (kind == NEED_RUN) ? rand_run() : rand_place();
			else
				it = $urandom_range(0, 1) ? rand_run() : rand_place();
			if ((kind == NEED_RUN && it.cmd == CMD_RUN) ||
				(kind == NEED_PLACE && it.cmd == CMD_PLACE))
				useful++;
			send_item(it);
			n++;
		end

		repeat (6)
			send_item($urandom_range(0, 1) ? rand_run() : rand_place());
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (board.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
